>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL; esk_seq.sv is the file that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define ESK_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a consequent follows from an antecedent in the same cycle.
`define ESK_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent follows in the cycle after an antecedent.
`define ESK_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/esk_pkg.sv
package esk_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int EV_W        = 108;
  localparam int IN_TDATA_W  = ((EV_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP_RD,
    S_POP_DATA,
    S_SCAN,
    S_NOP
  } state_t;

  // Last field sits in the lowest bits.
  typedef struct packed {
    logic [31:0] value2;
    logic [31:0] value1;
    logic [15:0] time_ofs;
    logic [15:0] id;
    logic [7:0]  channel;
    logic [3:0]  kind;
  } event_t;

endpackage

>>> rtl/core/esk_ram.sv
module esk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/esk_seq.sv
`include "assert_macros.svh"

module esk_seq #(
  parameter int DEPTH = esk_pkg::DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  esk_pkg::req_t    in_req,
  input  esk_pkg::event_t  in_ev,
  input  logic             out_free,
  output logic             in_ready,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output esk_pkg::event_t  ram_wdata,
  output logic [AW-1:0]    ram_raddr,
  input  esk_pkg::event_t  ram_rdata,
  output logic             res_valid,
  output esk_pkg::event_t  res_ev,
  output esk_pkg::status_t res_status,
  output logic [CW-1:0]    res_fill,
  output logic [CW-1:0]    res_removed
);
  import esk_pkg::*;

  state_t        state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic [CW-1:0] keep_r, keep_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  logic          dvld_r, dvld_nxt;
  event_t        ev_r, ev_nxt;
  logic          accept;
  logic          issue;
  logic          hit;

  assign accept = in_valid && in_ready;
  // The scan still has entries to read, and the id compare for the word just read.
  assign issue  = (rd_idx_r < fill_r);
  assign hit    = (ram_rdata.id == ev_r.id);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_req)
            REQ_PUSH:   state_nxt = S_PUSH;
            REQ_POP:    state_nxt = S_POP_RD;
            REQ_REMOVE: state_nxt = S_SCAN;
            default:    state_nxt = S_NOP;
          endcase
        end
      end
      S_POP_RD: state_nxt = (fill_r == '0) ? S_IDLE : S_POP_DATA;
      S_SCAN: begin
        if (!issue && !dvld_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    fill_nxt    = fill_r;
    rd_idx_nxt  = rd_idx_r;
    keep_nxt    = keep_r;
    removed_nxt = removed_r;
    dvld_nxt    = 1'b0;
    ev_nxt      = accept ? in_ev : ev_r;
    unique case (state_r)
      S_IDLE: begin
        rd_idx_nxt  = '0;
        keep_nxt    = '0;
        removed_nxt = '0;
      end
      S_PUSH: begin
        if (fill_r < CW'(DEPTH)) begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      S_POP_DATA: fill_nxt = fill_r - 1'b1;
      S_SCAN: begin
        rd_idx_nxt = rd_idx_r + CW'(issue);
        dvld_nxt   = issue;
        if (dvld_r) begin
          if (hit) begin
            removed_nxt = removed_r + 1'b1;
          end else begin
            keep_nxt = keep_r + 1'b1;
          end
        end
        if (!issue && !dvld_r) begin
          fill_nxt = keep_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = fill_r[AW-1:0];
    ram_wdata   = ev_r;
    ram_raddr   = rd_idx_r[AW-1:0];
    res_valid   = 1'b0;
    res_ev      = '0;
    res_status  = ST_OK;
    res_fill    = fill_nxt;
    res_removed = '0;
    unique case (state_r)
      S_IDLE: in_ready = out_free;
      S_PUSH: begin
        res_valid = 1'b1;
        if (fill_r < CW'(DEPTH)) begin
          ram_we = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      S_POP_RD: begin
        ram_raddr = AW'(fill_r - 1'b1);
        if (fill_r == '0) begin
          res_valid  = 1'b1;
          res_status = ST_EMPTY;
        end
      end
      S_POP_DATA: begin
        res_valid = 1'b1;
        res_ev    = ram_rdata;
      end
      S_SCAN: begin
        // Survivors move down to the keep position; it never passes the read position.
        ram_we    = dvld_r && !hit;
        ram_waddr = keep_r[AW-1:0];
        ram_wdata = ram_rdata;
        if (!issue && !dvld_r) begin
          res_valid   = 1'b1;
          res_removed = removed_r;
        end
      end
      S_NOP: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      rd_idx_r  <= '0;
      keep_r    <= '0;
      removed_r <= '0;
      dvld_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      rd_idx_r  <= rd_idx_nxt;
      keep_r    <= keep_nxt;
      removed_r <= removed_nxt;
      dvld_r    <= dvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
  end

  `ESK_ASSERT(a_fill_bound, clk, rst_n, fill_r <= CW'(DEPTH), "fill count above depth")
  `ESK_ASSERT_IMP(a_scan_count, clk, rst_n, state_r == S_SCAN,
    ({1'b0, keep_r} + {1'b0, removed_r} + (CW+1)'(dvld_r)) == {1'b0, rd_idx_r},
    "scan counters out of step")
  `ESK_ASSERT_NEXT(a_res_idle, clk, rst_n, res_valid, state_r == S_IDLE,
    "sequencer busy after result")
  `ESK_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_r != S_IDLE,
    "accepted word not started")

endmodule

>>> rtl/core/event_stack_keyed_removal.sv
// Last-in first-out stack of control events with remove-by-id.
// Input channel in_*: in_tuser carries the request (push, pop, remove by id,
// code 3 does nothing) and in_tdata the event. Output channel out_*: one
// word per request with the popped event (zero unless a good pop), the fill
// count after the request, an empty flag and the number of removed entries;
// out_tuser carries the status (ok, push dropped because full, pop on empty).
// A push, an empty pop, code 3 and a remove on an empty stack are answered
// as soon as the sequencer has taken them in; a good pop first reads the
// memory and then returns the data, and any other remove walks the stored
// entries one per cycle through the single read port of the event memory and
// writes survivors back down over the removed ones. The result word is
// registered before it leaves. One request is in flight at a time; the next
// one can be accepted at the edge that takes the result.
// in_tready is low while a request is being worked on and while a finished
// word waits on a stalled receiver; it rises in the cycle out_tready takes it.
// Reset empties the stack at once; no clearing pass is run, since slots at
// or above the fill count are never returned.
module event_stack_keyed_removal #(
  parameter int DEPTH = esk_pkg::DEPTH_DEF,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int OUT_W = esk_pkg::EV_W + 2 * CW + 1,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // kind, channel, id, time, value1, value2
  input  logic [esk_pkg::IN_TDATA_W-1:0] in_tdata,
  // req_type
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // kind, channel, id, time, value1, value2, fill_after, empty_after, removed_count
  output logic [OUT_TDATA_W-1:0]         out_tdata,
  // status
  output logic [1:0]                     out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready
);
  import esk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  event_t        ram_wdata;
  event_t        ram_rdata;
  logic          res_valid;
  event_t        res_ev;
  status_t       res_status;
  logic [CW-1:0] res_fill;
  logic [CW-1:0] res_removed;
  logic          out_free;

  logic          out_tvalid_r, out_tvalid_nxt;
  event_t        out_ev_r;
  status_t       out_status_r;
  logic [CW-1:0] out_fill_r;
  logic [CW-1:0] out_removed_r;

  assign out_free = !out_tvalid_r || out_tready;

  esk_seq #(.DEPTH(DEPTH)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_req     (req_t'(in_tuser)),
    .in_ev      (event_t'(in_tdata[EV_W-1:0])),
    .out_free   (out_free),
    .in_ready   (in_tready),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_valid  (res_valid),
    .res_ev     (res_ev),
    .res_status (res_status),
    .res_fill   (res_fill),
    .res_removed(res_removed)
  );

  esk_ram #(.WIDTH(EV_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (res_valid) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_ev_r      <= res_ev;
      out_status_r  <= res_status;
      out_fill_r    <= res_fill;
      out_removed_r <= res_removed;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_removed_r,
                       (out_fill_r == '0), out_fill_r, out_ev_r};

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import esk_pkg::*;

  localparam int DEPTH = esk_pkg::DEPTH_DEF;
  localparam int IN_W = esk_pkg::IN_TDATA_W;
  localparam int N_RANDOM = 1250;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT_WORD = 1000;
  localparam int DRAIN_CYCLES = 30;

  // Request code with no function; the block must leave the stack alone.
  localparam logic [1:0] REQ_NOP = 2'd3;

  localparam event_t EV_ZERO = '0;
  localparam event_t EV_MAX = '1;

  typedef struct packed {
    status_t     status;
    logic [4:0]  removed;
    logic        empty;
    logic [4:0]  fill;
    event_t      ev;
  } note_result_t;

  // Layout of out_tdata from the highest bit down.
  typedef struct packed {
    logic [4:0]  removed;
    logic        empty;
    logic [4:0]  fill;
    event_t      ev;
  } out_word_t;

  typedef struct packed {
    logic [1:0]   req;
    event_t       ev;
    logic         fixed;
    note_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [IN_W-1:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [119:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;

  int tx_idle_pct = 6;
  int rx_idle_pct = 78;
  int failures = 0;
  int unsigned cycle_count = 0;

  event_t stack_mem [DEPTH];
  int unsigned stack_fill = 0;
  note_result_t note_results_due[$];
  stim_row_t directed_rows[$];

  event_stack_keyed_removal dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic note_result_t predict_note_result(logic [1:0] req, event_t ev);
    note_result_t r;
    int unsigned keep;
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_PUSH: begin
        if (stack_fill < DEPTH) begin
          stack_mem[stack_fill] = ev;
          stack_fill++;
        end else begin
          r.status = ST_FULL;
        end
      end
      REQ_POP: begin
        if (stack_fill > 0) begin
          stack_fill--;
          r.ev = stack_mem[stack_fill];
        end else begin
          r.status = ST_EMPTY;
        end
      end
      REQ_REMOVE: begin
        // Survivors slide down in order; runs of matching ids all go.
        keep = 0;
        for (int i = 0; i < stack_fill; i++) begin
          if (stack_mem[i].id == ev.id) begin
            r.removed++;
          end else begin
            stack_mem[keep] = stack_mem[i];
            keep++;
          end
        end
        stack_fill = keep;
      end
      default: ;
    endcase
    r.fill = 5'(stack_fill);
    r.empty = (stack_fill == 0);
    return r;
  endfunction

  function automatic void add_row(logic [1:0] req, event_t ev, logic fixed,
                                  note_result_t want);
    stim_row_t row;
    row.req = req;
    row.ev = ev;
    row.fixed = fixed;
    row.want = want;
    directed_rows.push_back(row);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  task automatic offer_request(input stim_row_t row);
    int gap;
    note_result_t pred;
    gap = 0;
    while ($urandom_range(0, 99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser <= row.req;
    in_tdata <= IN_W'(row.ev);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    pred = predict_note_result(row.req, row.ev);
    note_results_due.push_back(row.fixed ? row.want : pred);
  endtask

  function automatic event_t random_event(int id_span);
    event_t ev;
    ev.kind = 4'($urandom_range(0, 15));
    ev.channel = 8'($urandom_range(0, 255));
    ev.time_ofs = 16'($urandom_range(0, 65535));
    ev.value1 = $urandom;
    ev.value2 = $urandom;
    // Mostly a small pool of ids so that removals find matches, often adjacent.
    if ($urandom_range(0, 99) < 75) ev.id = 16'($urandom_range(0, id_span));
    else ev.id = 16'($urandom_range(0, 65535));
    return ev;
  endfunction

  initial begin : result_side
    out_word_t got_w;
    note_result_t want_r;
    int hold_left;
    int words_seen;
    bit held;
    hold_left = 0;
    words_seen = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got_w = out_word_t'(out_tdata[$bits(out_word_t)-1:0]);
        if (note_results_due.size() == 0) begin
          $error("result word arrived with no request pending");
          failures++;
        end else begin
          want_r = note_results_due.pop_front();
          check_field("kind", want_r.ev.kind, got_w.ev.kind);
          check_field("channel", want_r.ev.channel, got_w.ev.channel);
          check_field("id", want_r.ev.id, got_w.ev.id);
          check_field("time", want_r.ev.time_ofs, got_w.ev.time_ofs);
          check_field("value1", want_r.ev.value1, got_w.ev.value1);
          check_field("value2", want_r.ev.value2, got_w.ev.value2);
          check_field("fill_after", want_r.fill, got_w.fill);
          check_field("empty_after", want_r.empty, got_w.empty);
          check_field("removed_count", want_r.removed, got_w.removed);
          check_field("status", want_r.status, out_tuser);
        end
        words_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!held && words_seen >= HOLD_AT_WORD) begin
        // Long stall on the result side while requests keep coming.
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : request_side
    event_t ev;
    stim_row_t row;
    int mode;
    int id_span;
    int pick;
    int push_pct;
    int pop_pct;
    int nop_pct;

    add_row(REQ_POP, EV_ZERO, 1'b1,
            '{status: ST_EMPTY, removed: 5'd0, empty: 1'b1, fill: 5'd0, ev: EV_ZERO});
    add_row(REQ_PUSH, EV_MAX, 1'b1,
            '{status: ST_OK, removed: 5'd0, empty: 1'b0, fill: 5'd1, ev: EV_ZERO});
    add_row(REQ_POP, EV_ZERO, 1'b1,
            '{status: ST_OK, removed: 5'd0, empty: 1'b1, fill: 5'd0, ev: EV_MAX});
    add_row(REQ_REMOVE, EV_ZERO, 1'b1,
            '{status: ST_OK, removed: 5'd0, empty: 1'b1, fill: 5'd0, ev: EV_ZERO});
    // A null event is stored like any other.
    add_row(REQ_PUSH, EV_ZERO, 1'b0, '0);
    for (int i = 1; i < DEPTH; i++) begin
      ev.kind = 4'(i);
      ev.channel = 8'(i * 17);
      ev.id = (i % 5 < 2) ? 16'h00A5 : 16'(16'h1000 + i);
      ev.time_ofs = 16'(16'hFFFF - i);
      ev.value1 = {16'hBEEF, 16'(i)};
      ev.value2 = ~{16'h5A5A, 16'(i)};
      add_row(REQ_PUSH, ev, 1'b0, '0);
    end
    add_row(REQ_PUSH, EV_MAX, 1'b1,
            '{status: ST_FULL, removed: 5'd0, empty: 1'b0, fill: 5'd16, ev: EV_ZERO});
    add_row(REQ_NOP, EV_MAX, 1'b1,
            '{status: ST_OK, removed: 5'd0, empty: 1'b0, fill: 5'd16, ev: EV_ZERO});
    ev = EV_ZERO;
    ev.id = 16'h00A5;
    add_row(REQ_REMOVE, ev, 1'b0, '0);
    ev.id = 16'h7777;
    add_row(REQ_REMOVE, ev, 1'b0, '0);
    add_row(REQ_POP, EV_ZERO, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) offer_request(directed_rows[i]);

    mode = 0;
    id_span = 3;
    push_pct = 70;
    pop_pct = 15;
    nop_pct = 2;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 400) begin
        tx_idle_pct = 78;
        rx_idle_pct = 6;
      end else if (n == 825) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // Swing between filling and draining so both ends of the stack are hit.
      if (n % 40 == 0) begin
        mode = $urandom_range(0, 2);
        case ($urandom_range(0, 2))
          0: id_span = 0;
          1: id_span = 1;
          default: id_span = 3;
        endcase
        case (mode)
          0: begin push_pct = 70; pop_pct = 15; end
          1: begin push_pct = 20; pop_pct = 60; end
          default: begin push_pct = 45; pop_pct = 35; end
        endcase
      end
      row = '0;
      row.ev = random_event(id_span);
      pick = $urandom_range(0, 99);
      if (pick < nop_pct) begin
        row.req = REQ_NOP;
      end else if (pick < nop_pct + push_pct) begin
        row.req = REQ_PUSH;
      end else if (pick < nop_pct + push_pct + pop_pct) begin
        row.req = REQ_POP;
      end else begin
        row.req = REQ_REMOVE;
        if (stack_fill > 0 && $urandom_range(0, 99) < 50)
          row.ev.id = stack_mem[$urandom_range(0, stack_fill - 1)].id;
      end
      offer_request(row);
    end
    in_tvalid <= 1'b0;

    while (note_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && note_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
